[hdl/radial_falloff_rgb565_blend_defines.svh]
// Assertion helpers for the falloff blend block.
`ifndef RADIAL_FALLOFF_RGB565_BLEND_DEFINES_SVH
`define RADIAL_FALLOFF_RGB565_BLEND_DEFINES_SVH

// Expression must hold at every clock edge out of reset.
`define RFB_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define RFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the same cycle.
`define RFB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hdl/rfb_pkg.sv]
`default_nettype none

package rfb_pkg;

  localparam int X_BITS     = 9;
  localparam int R_BITS     = 17;
  localparam int T_BITS     = 17;
  localparam int T_SHIFT    = 18;
  localparam int Q_W        = T_BITS + 2;
  localparam int PIX_BITS   = 16;
  localparam int CFG_W      = 17;
  localparam int F_BITS     = 8;
  localparam int FULL_ALPHA = 256;
  localparam logic [15:0] ALPHA_MUL = 16'd39322;

  typedef enum logic [1:0] {
    CFG_CENTER_X     = 2'd0,
    CFG_RADIUS_SCALE = 2'd1,
    CFG_ROW_OFFSET   = 2'd2,
    CFG_LEAF_COLOR   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                valid;
    logic [T_BITS-1:0]   t;
    logic [PIX_BITS-1:0] pixel;
  } dist_word_t;

  typedef struct packed {
    logic                valid;
    logic [F_BITS-1:0]   f;
    logic [PIX_BITS-1:0] pixel;
  } alpha_word_t;

endpackage

`default_nettype wire

[hdl/rfb_dist.sv]
`default_nettype none

module rfb_dist
  import rfb_pkg::*;
#(
  parameter int COORD_BITS = 9
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input  wire logic [X_BITS-1:0]   pixel_x_i,
  input  wire logic [PIX_BITS-1:0] pixel_in_i,
  input  wire logic [X_BITS-1:0]   center_x_i,
  input  wire logic [R_BITS-1:0]   radius_scale_i,
  output dist_word_t               dist_o
);

  localparam int XW = (COORD_BITS < X_BITS) ? COORD_BITS : X_BITS;
  localparam int PW = 2 * XW + R_BITS;

  logic                 s1_valid_q, s2_valid_q, s3_valid_q;
  logic signed [XW:0]   dx_d, dx_q;
  logic [PIX_BITS-1:0]  s1_pix_q, s2_pix_q, s3_pix_q;
  logic signed [2*XW+1:0] sq;
  logic [2*XW-1:0]      dx2_d, dx2_q;
  logic [PW-1:0]        prod;
  logic [T_BITS-1:0]    t_d, t_q;

  always_comb begin
    dx_d  = $signed({1'b0, pixel_x_i[XW-1:0]}) - $signed({1'b0, center_x_i[XW-1:0]});
    sq    = dx_q * dx_q;
    dx2_d = sq[2*XW-1:0];
    prod  = PW'(dx2_q) * PW'(radius_scale_i);
    t_d   = T_BITS'(prod >> T_SHIFT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q     <= dx_d;
    s1_pix_q <= pixel_in_i;
    dx2_q    <= dx2_d;
    s2_pix_q <= s1_pix_q;
    t_q      <= t_d;
    s3_pix_q <= s2_pix_q;
  end

  assign dist_o.valid = s3_valid_q;
  assign dist_o.t     = t_q;
  assign dist_o.pixel = s3_pix_q;

endmodule

`default_nettype wire

[hdl/rfb_alpha.sv]
`default_nettype none

module rfb_alpha
  import rfb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dist_word_t        dist_i,
  input  wire logic [X_BITS-1:0] row_offset_i,
  output alpha_word_t            alpha_o
);

  logic [Q_W-1:0]      q_full;
  logic [8:0]          q_clamp;
  logic [24:0]         prod;
  logic                valid_q;
  logic [F_BITS-1:0]   f_d, f_q;
  logic [PIX_BITS-1:0] pix_q;

  always_comb begin
    q_full  = Q_W'(FULL_ALPHA) - Q_W'(row_offset_i) - Q_W'(dist_i.t);
    // negative strength clamps to zero
    q_clamp = q_full[Q_W-1] ? 9'd0 : q_full[8:0];
    prod    = 25'(q_clamp) * 25'(ALPHA_MUL);
    f_d     = prod[23:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= dist_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q   <= f_d;
    pix_q <= dist_i.pixel;
  end

  assign alpha_o.valid = valid_q;
  assign alpha_o.f     = f_q;
  assign alpha_o.pixel = pix_q;

endmodule

`default_nettype wire

[hdl/rfb_mix.sv]
`default_nettype none

module rfb_mix
  import rfb_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire alpha_word_t         alpha_i,
  input  wire logic [PIX_BITS-1:0] leaf_color_i,
  output logic                     out_valid_o,
  output logic [PIX_BITS-1:0]      pixel_out_o
);

  function automatic logic [5:0] mix_ch(input logic [5:0] c, input logic [5:0] l,
                                        input logic [8:0] g, input logic [7:0] f);
    logic [14:0] acc;
    acc = 15'(c) * 15'(g) + 15'(l) * 15'(f);
    return acc[13:8];
  endfunction

  logic [8:0]          g;
  logic [5:0]          r_mix, g_mix, b_mix;
  logic                valid_q;
  logic [PIX_BITS-1:0] pix_d, pix_q;

  always_comb begin
    g     = 9'(FULL_ALPHA) - {1'b0, alpha_i.f};
    r_mix = mix_ch({1'b0, alpha_i.pixel[15:11]}, {1'b0, leaf_color_i[15:11]}, g, alpha_i.f);
    g_mix = mix_ch(alpha_i.pixel[10:5], leaf_color_i[10:5], g, alpha_i.f);
    b_mix = mix_ch({1'b0, alpha_i.pixel[4:0]}, {1'b0, leaf_color_i[4:0]}, g, alpha_i.f);
    pix_d = {r_mix[4:0], g_mix, b_mix[4:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= alpha_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
  end

  assign out_valid_o = valid_q;
  assign pixel_out_o = pix_q;

endmodule

`default_nettype wire

[hdl/radial_falloff_rgb565_blend.sv]
// An accepted word passes through the register stages listed below and is then strobed on out_valid_o.
// Throughput: one word per clock; five register stages (distance, square, scale,
// alpha multiply, channel blend), so start may stay high every cycle and busy is never set.
// Reset clears the stage valid bits and all configuration registers to zero.
// The receiver cannot stall; each result is present for exactly one cycle.
`default_nettype none

`include "radial_falloff_rgb565_blend_defines.svh"

module radial_falloff_rgb565_blend
  import rfb_pkg::*;
#(
  parameter int COORD_BITS = 9
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [X_BITS-1:0]   pixel_x_i,
  input  wire logic [PIX_BITS-1:0] pixel_in_i,
  output logic                     out_valid_o,
  output logic [PIX_BITS-1:0]      pixel_out_o,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [CFG_W-1:0]    cfg_data_i
);

  logic [X_BITS-1:0]   center_x_q, row_offset_q;
  logic [R_BITS-1:0]   radius_scale_q;
  logic [PIX_BITS-1:0] leaf_color_q;
  dist_word_t          dist_w;
  alpha_word_t         alpha_w;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q     <= '0;
      radius_scale_q <= '0;
      row_offset_q   <= '0;
      leaf_color_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CENTER_X:     center_x_q     <= cfg_data_i[X_BITS-1:0];
        CFG_RADIUS_SCALE: radius_scale_q <= cfg_data_i[R_BITS-1:0];
        CFG_ROW_OFFSET:   row_offset_q   <= cfg_data_i[X_BITS-1:0];
        CFG_LEAF_COLOR:   leaf_color_q   <= cfg_data_i[PIX_BITS-1:0];
        default: ;
      endcase
    end
  end

  rfb_dist #(
    .COORD_BITS(COORD_BITS)
  ) u_dist (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (start && !busy),
    .pixel_x_i      (pixel_x_i),
    .pixel_in_i     (pixel_in_i),
    .center_x_i     (center_x_q),
    .radius_scale_i (radius_scale_q),
    .dist_o         (dist_w)
  );

  rfb_alpha u_alpha (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dist_i       (dist_w),
    .row_offset_i (row_offset_q),
    .alpha_o      (alpha_w)
  );

  rfb_mix u_mix (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .alpha_i      (alpha_w),
    .leaf_color_i (leaf_color_q),
    .out_valid_o  (out_valid_o),
    .pixel_out_o  (pixel_out_o)
  );

  `RFB_ASSERT_ALWAYS(a_out_follows_alpha, out_valid_o == $past(alpha_w.valid), "strobe lost")
  `RFB_ASSERT_IMPL(a_alpha_follows_dist, alpha_w.valid, $past(dist_w.valid), "alpha word invented")
  `RFB_ASSERT_NEXT(a_zero_alpha_pass, alpha_w.valid && (alpha_w.f == '0), out_valid_o && (pixel_out_o == $past(alpha_w.pixel)), "zero alpha must pass pixel")

endmodule

`default_nettype wire
